// ----- rtl/core/wpg_pkg.sv -----
// ----------------------------------------------------------------------------
// Windowed pulse train generator - shared definitions
// Register map codes, fixed field widths and the side-band that travels
// alongside the remainder pipeline.
// ----------------------------------------------------------------------------
package wpg_pkg;

    // Fixed field widths
    localparam int PERIOD_W  = 31;
    localparam int DUTY_W    = 18;
    localparam int REG_IDX_W = 3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_START  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_END    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_PERIOD  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DUTY_FRACTION = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_OFFSET  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL_OFFSET  = 3'd6;

    // Travels with each sample through the remainder pipeline
    typedef struct packed {
        logic in_win;
        logic neg;
    } t_side;

endpackage

// ----- rtl/core/wpg_rem_pipe.sv -----
// ----------------------------------------------------------------------------
// Remainder pipeline
// Restoring remainder of an unsigned magnitude by the period, one dividend
// bit per register stage. All stages advance together on i_en.
// ----------------------------------------------------------------------------
module wpg_rem_pipe #(
    parameter int MAG_W = 33
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [MAG_W-1:0]               i_mag,
    input  wpg_pkg::t_side                 i_side,
    input  logic [wpg_pkg::PERIOD_W-1:0]   i_period,
    output logic                           o_valid,
    output logic [wpg_pkg::PERIOD_W-1:0]   o_rem,
    output wpg_pkg::t_side                 o_side
);

    localparam int PW = wpg_pkg::PERIOD_W;

    logic                 r_v    [MAG_W];
    logic [PW-1:0]        r_rem  [MAG_W];
    logic [MAG_W-1:0]     r_mag  [MAG_W-1];
    wpg_pkg::t_side       r_side [MAG_W];

    logic [PW-1:0]        rem_src [MAG_W];
    logic [MAG_W-1:0]     mag_src [MAG_W];
    logic [PW-1:0]        n_rem   [MAG_W];
    logic [MAG_W-1:0]     n_mag   [MAG_W];

    // stage inputs: first stage from the port, the rest from the previous stage
    always_comb begin
        rem_src[0] = '0;
        mag_src[0] = i_mag;
        for (int k = 1; k < MAG_W; k++) begin
            rem_src[k] = r_rem[k-1];
            mag_src[k] = r_mag[k-1];
        end
    end

    // shift in the next dividend bit, subtract the period when it fits
    always_comb begin
        logic [PW:0] trial;
        trial = '0;
        for (int k = 0; k < MAG_W; k++) begin
            trial = {rem_src[k], mag_src[k][MAG_W-1]};
            if (trial >= {1'b0, i_period}) begin
                n_rem[k] = PW'(trial - {1'b0, i_period});
            end else begin
                n_rem[k] = trial[PW-1:0];
            end
            n_mag[k] = mag_src[k] << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAG_W; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < MAG_W; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 0; k < MAG_W; k++) begin
                r_rem[k] <= n_rem[k];
            end
            for (int k = 1; k < MAG_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < MAG_W - 1; k++) begin
                r_mag[k] <= n_mag[k];
            end
        end
    end

    assign o_valid = r_v[MAG_W-1];
    assign o_rem   = r_rem[MAG_W-1];
    assign o_side  = r_side[MAG_W-1];

endmodule

// ----- rtl/core/windowed_pulse_train_generator.sv -----
// ----------------------------------------------------------------------------
// Windowed pulse train generator
// Rectangular pulse train over signed fixed-point time, gated by a window.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel: i_sample_valid / o_sample_ready carry one sample time
//   per transfer. Result channel: o_result_valid / i_result_ready carry the
//   level and the inside, high and saturated flags, one result per sample,
//   in order.
//   Each sample passes through stages s0 to s3, the remainder pipeline (one
//   stage per dividend bit), stages s4 and s5 and the output register that
//   offers the result. Throughput is one sample per cycle while the result
//   channel does not stall. Registers are to be written through the APB
//   port while no sample is in flight; the block does not enforce this.
//   pready is tied high and prdata reads back the stored value. Reset
//   clears all valid bits and loads the documented register defaults.
//   When the receiver stalls, the result is held in the output register and
//   the pipeline keeps taking samples until its last stage is occupied;
//   only then does o_sample_ready drop, with nothing lost or repeated.
// ----------------------------------------------------------------------------
module windowed_pulse_train_generator #(
    parameter int TIME_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // APB configuration
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [((TIME_BITS > 32) ? 6 : 5)-1:0]      paddr,
    input  logic [((TIME_BITS > 32) ? 64 : 32)-1:0]    pwdata,
    output logic [((TIME_BITS > 32) ? 64 : 32)-1:0]    prdata,
    output logic                                       pready,
    // sample channel
    input  logic                                       i_sample_valid,
    output logic                                       o_sample_ready,
    input  logic signed [TIME_BITS-1:0]                i_sample_time,
    // result channel
    output logic                                       o_result_valid,
    input  logic                                       i_result_ready,
    output logic signed [TIME_BITS-1:0]                o_factor_value,
    output logic                                       o_inside_window,
    output logic                                       o_pulse_high,
    output logic                                       o_saturated
);

    localparam int TB       = TIME_BITS;
    localparam int PW       = wpg_pkg::PERIOD_W;
    localparam int DW       = wpg_pkg::DUTY_W;
    localparam int DATA_W   = (TIME_BITS > 32) ? 64 : 32;
    localparam int ADDR_W   = (TIME_BITS > 32) ? 6 : 5;
    localparam int STRIDE_L = (TIME_BITS > 32) ? 3 : 2;
    localparam int MAG_W    = TB + 1;
    localparam int PROD_W   = DW + PW;
    localparam int CMP_W    = (PW + FRAC_BITS > PROD_W) ? PW + FRAC_BITS : PROD_W;

    localparam logic [PW-1:0] PERIOD_ONE = PW'(64'd1 << FRAC_BITS);
    localparam logic [DW-1:0] DUTY_RST   = DW'((64'd1 << FRAC_BITS) >> 1);
    localparam logic [TB-1:0] AMP_RST    = TB'(64'd1 << FRAC_BITS);
    localparam logic [TB-1:0] WORD_MAX   = {1'b0, {(TB-1){1'b1}}};
    localparam logic [TB-1:0] WORD_MIN   = {1'b1, {(TB-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TB-1:0] r_start, r_end, r_phase, r_amp, r_level;
    logic [PW-1:0] r_period;
    logic [DW-1:0] r_duty;

    logic                    cfg_wr;
    logic [wpg_pkg::REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:STRIDE_L];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_end    <= '0;
            r_period <= PERIOD_ONE;
            r_duty   <= DUTY_RST;
            r_phase  <= '0;
            r_amp    <= AMP_RST;
            r_level  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                wpg_pkg::REG_WINDOW_START:  r_start  <= pwdata[TB-1:0];
                wpg_pkg::REG_WINDOW_END:    r_end    <= pwdata[TB-1:0];
                wpg_pkg::REG_PULSE_PERIOD:  r_period <= pwdata[PW-1:0];
                wpg_pkg::REG_DUTY_FRACTION: r_duty   <= pwdata[DW-1:0];
                wpg_pkg::REG_PHASE_OFFSET:  r_phase  <= pwdata[TB-1:0];
                wpg_pkg::REG_AMPLITUDE:     r_amp    <= pwdata[TB-1:0];
                wpg_pkg::REG_LEVEL_OFFSET:  r_level  <= pwdata[TB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            wpg_pkg::REG_WINDOW_START:  prdata = DATA_W'(r_start);
            wpg_pkg::REG_WINDOW_END:    prdata = DATA_W'(r_end);
            wpg_pkg::REG_PULSE_PERIOD:  prdata = DATA_W'(r_period);
            wpg_pkg::REG_DUTY_FRACTION: prdata = DATA_W'(r_duty);
            wpg_pkg::REG_PHASE_OFFSET:  prdata = DATA_W'(r_phase);
            wpg_pkg::REG_AMPLITUDE:     prdata = DATA_W'(r_amp);
            wpg_pkg::REG_LEVEL_OFFSET:  prdata = DATA_W'(r_level);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Values derived from configuration only
    // ------------------------------------------------------------------
    logic [PW-1:0]     r_period_eff;
    logic [PROD_W-1:0] r_duty_prod;
    logic [TB-1:0]     r_high_val;
    logic              r_high_sat;
    logic [TB:0]       hi_sum;

    assign hi_sum = {r_amp[TB-1], r_amp} + {r_level[TB-1], r_level};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_eff <= PERIOD_ONE;
        end else begin
            r_period_eff <= (r_period == '0) ? PERIOD_ONE : r_period;
        end
    end

    always_ff @(posedge i_clk) begin
        r_duty_prod <= PROD_W'(r_duty) * PROD_W'(r_period_eff);
        r_high_sat  <= hi_sum[TB] ^ hi_sum[TB-1];
        if (hi_sum[TB] ^ hi_sum[TB-1]) begin
            r_high_val <= hi_sum[TB] ? WORD_MIN : WORD_MAX;
        end else begin
            r_high_val <= hi_sum[TB-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sample pipeline
    // ------------------------------------------------------------------
    logic en;

    logic              r_s0_v, r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_out_v;
    logic [TB-1:0]     r_s0_t;
    logic              r_s1_in, r_s2_in, r_s4_in;
    logic [TB:0]       r_s1_sum;
    logic [TB+1:0]     r_s2_d;
    logic [MAG_W-1:0]  r_s3_mag;
    wpg_pkg::t_side    r_s3_side;
    logic [PW-1:0]     r_s4_r;
    logic              r_s5_in, r_s5_high, r_s5_sat;
    logic [TB-1:0]     r_s5_val;
    logic              r_out_in, r_out_high, r_out_sat;
    logic [TB-1:0]     r_out_val;

    logic [TB+1:0]     neg_d;
    logic              rp_valid;
    logic [PW-1:0]     rp_rem;
    wpg_pkg::t_side    rp_side;
    logic              cmp_high;

    // advance while the last stage is empty or its result can move on
    assign en             = !r_s5_v || !r_out_v || i_result_ready;
    assign o_sample_ready = en;

    assign neg_d    = (TB+2)'(0) - r_s2_d;
    assign cmp_high = r_s4_in &&
                      (CMP_W'({r_s4_r, {FRAC_BITS{1'b0}}}) < CMP_W'(r_duty_prod));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_sample_valid;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= rp_valid;
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_t    <= i_sample_time;
            // window test and first half of the offset sum
            r_s1_in   <= ($signed(r_start) <= $signed(r_s0_t)) &&
                         ($signed(r_s0_t) <= $signed(r_end));
            r_s1_sum  <= {r_s0_t[TB-1], r_s0_t} + {r_phase[TB-1], r_phase};
            r_s2_in   <= r_s1_in;
            r_s2_d    <= {r_s1_sum[TB], r_s1_sum} - {{2{r_start[TB-1]}}, r_start};
            // split into sign and magnitude for the remainder pipeline
            r_s3_side.in_win <= r_s2_in;
            r_s3_side.neg    <= r_s2_d[TB+1];
            r_s3_mag  <= r_s2_d[TB+1] ? neg_d[MAG_W-1:0] : r_s2_d[MAG_W-1:0];
            // fold a negative dividend back to a floored remainder
            r_s4_in   <= rp_side.in_win;
            if (rp_side.neg && (rp_rem != '0)) begin
                r_s4_r <= r_period_eff - rp_rem;
            end else begin
                r_s4_r <= rp_rem;
            end
            r_s5_in   <= r_s4_in;
            r_s5_high <= cmp_high;
            r_s5_sat  <= cmp_high && r_high_sat;
            if (!r_s4_in) begin
                r_s5_val <= '0;
            end else if (cmp_high) begin
                r_s5_val <= r_high_val;
            end else begin
                r_s5_val <= r_level;
            end
        end
    end

    wpg_rem_pipe #(
        .MAG_W (MAG_W)
    ) u_rem_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_s3_v),
        .i_mag    (r_s3_mag),
        .i_side   (r_s3_side),
        .i_period (r_period_eff),
        .o_valid  (rp_valid),
        .o_rem    (rp_rem),
        .o_side   (rp_side)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en && r_s5_v) begin
            r_out_v <= 1'b1;
        end else if (i_result_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s5_v) begin
            r_out_val  <= r_s5_val;
            r_out_in   <= r_s5_in;
            r_out_high <= r_s5_high;
            r_out_sat  <= r_s5_sat;
        end
    end

    assign o_result_valid  = r_out_v;
    assign o_factor_value  = r_out_val;
    assign o_inside_window = r_out_in;
    assign o_pulse_high    = r_out_high;
    assign o_saturated     = r_out_sat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_sample_ready |-> (r_s5_v && r_out_v))
        else $error("sample channel stalled with room in the pipeline");

    a_period_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_period_eff != '0)
        else $error("effective period is zero");

    a_high_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!o_pulse_high || o_inside_window) &&
                           (!o_saturated || o_pulse_high))
        else $error("pulse flags inconsistent with window flag");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_inside_window) |-> (o_factor_value == '0))
        else $error("non-zero level outside the window");

endmodule

// ----- tb/sv/windowed_pulse_train_generator_test.sv -----
// ----------------------------------------------------------------------------
// Windowed pulse train generator - block-level test
// Drives sample times through the valid/ready sample channel in random
// bursts, collects results under a randomly stalling receiver and checks each
// one against a local calculation of the window, floored remainder, duty test
// and saturated level. Register settings change between phases over APB,
// always with the pipeline drained.
// ----------------------------------------------------------------------------
module windowed_pulse_train_generator_test;

    localparam int      FRAC_W       = 16;
    localparam int      LATENCY      = 39;
    localparam int      STALL_LIMIT  = 2000;
    localparam int      RANDOM_ITEMS = 1075;
    localparam longint  ONE_SEC      = 64'sd65536;
    localparam longint  MAX_LEVEL    = 64'sd2147483647;
    localparam longint  MIN_LEVEL    = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] level;
        logic        in_win;
        logic        high;
        logic        sat;
    } t_level_result;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [4:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_sample_valid  = 1'b0;
    logic        o_sample_ready;
    logic [31:0] i_sample_time   = '0;
    logic        o_result_valid;
    logic        i_result_ready  = 1'b0;
    logic [31:0] o_factor_value;
    logic        o_inside_window;
    logic        o_pulse_high;
    logic        o_saturated;

    // Local copy of the register file
    logic signed [31:0] cfg_start  = 32'sd0;
    logic signed [31:0] cfg_end    = 32'sd0;
    logic [30:0]        cfg_period = 31'd65536;
    logic [17:0]        cfg_duty   = 18'd32768;
    logic signed [31:0] cfg_phase  = 32'sd0;
    logic signed [31:0] cfg_amp    = 32'sd65536;
    logic signed [31:0] cfg_level  = 32'sd0;

    logic [31:0]   pending_times[$];
    t_level_result expected_levels[$];
    t_level_result got_level;
    t_level_result want_level;
    int            fail_count   = 0;
    int            gap_left     = 0;
    int            burst_left   = 0;
    int            stall_left   = 0;
    int            ready_mode   = 0;
    int            mode_left    = 0;
    int            quiet_cycles = 0;
    int            random_samples = 0;
    int            phase_len;

    windowed_pulse_train_generator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_sample_valid  (i_sample_valid),
        .o_sample_ready  (o_sample_ready),
        .i_sample_time   (i_sample_time),
        .o_result_valid  (o_result_valid),
        .i_result_ready  (i_result_ready),
        .o_factor_value  (o_factor_value),
        .o_inside_window (o_inside_window),
        .o_pulse_high    (o_pulse_high),
        .o_saturated     (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_level_result predict_level(input logic [31:0] t_bits);
        longint        t;
        longint        ws;
        longint        we;
        longint        p;
        longint        d;
        longint        r;
        longint        s;
        t_level_result res;
        t   = longint'($signed(t_bits));
        ws  = longint'(cfg_start);
        we  = longint'(cfg_end);
        res = '0;
        if (ws <= t && t <= we) begin
            p = (cfg_period == '0) ? ONE_SEC : longint'(cfg_period);
            d = t + longint'(cfg_phase) - ws;
            // floored remainder: fold a negative truncated one back into range
            r = d % p;
            if (r < 0) begin
                r = r + p;
            end
            res.in_win = 1'b1;
            if ((r << FRAC_W) < longint'(cfg_duty) * p) begin
                s = longint'(cfg_amp) + longint'(cfg_level);
                res.high = 1'b1;
                if (s > MAX_LEVEL) begin
                    s       = MAX_LEVEL;
                    res.sat = 1'b1;
                end else if (s < MIN_LEVEL) begin
                    s       = MIN_LEVEL;
                    res.sat = 1'b1;
                end
                res.level = s[31:0];
            end else begin
                res.level = cfg_level;
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] pick_time();
        longint unsigned span;
        longint unsigned offs;
        case ($urandom_range(0, 9))
            0, 1: begin
                return $urandom;
            end
            2: begin
                case ($urandom_range(0, 3))
                    0:       return cfg_start - 32'd1;
                    1:       return cfg_start;
                    2:       return cfg_end;
                    default: return cfg_end + 32'd1;
                endcase
            end
            default: begin
                if (cfg_start > cfg_end) begin
                    return $urandom;
                end
                span = longint'(cfg_end) - longint'(cfg_start) + 1;
                offs = {$urandom, $urandom};
                return cfg_start + 32'(offs % span);
            end
        endcase
    endfunction

    task automatic write_reg(input logic [wpg_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            wpg_pkg::REG_WINDOW_START:  cfg_start  = value;
            wpg_pkg::REG_WINDOW_END:    cfg_end    = value;
            wpg_pkg::REG_PULSE_PERIOD:  cfg_period = value[30:0];
            wpg_pkg::REG_DUTY_FRACTION: cfg_duty   = value[17:0];
            wpg_pkg::REG_PHASE_OFFSET:  cfg_phase  = value;
            wpg_pkg::REG_AMPLITUDE:     cfg_amp    = value;
            wpg_pkg::REG_LEVEL_OFFSET:  cfg_level  = value;
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [31:0] ws, input logic [31:0] we,
                           input logic [31:0] per, input logic [31:0] duty,
                           input logic [31:0] ph, input logic [31:0] amp,
                           input logic [31:0] lvl);
        write_reg(wpg_pkg::REG_WINDOW_START, ws);
        write_reg(wpg_pkg::REG_WINDOW_END, we);
        write_reg(wpg_pkg::REG_PULSE_PERIOD, per);
        write_reg(wpg_pkg::REG_DUTY_FRACTION, duty);
        write_reg(wpg_pkg::REG_PHASE_OFFSET, ph);
        write_reg(wpg_pkg::REG_AMPLITUDE, amp);
        write_reg(wpg_pkg::REG_LEVEL_OFFSET, lvl);
    endtask

    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return 32'h7fff_0000 + $urandom_range(0, 32'hffff);
            1:       return 32'h8000_0000 + $urandom_range(0, 32'hffff);
            2:       return $urandom_range(0, 262143) - 32'd131072;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_config();
        logic [31:0] ws;
        logic [31:0] we;
        logic [31:0] swap;
        logic [31:0] per;
        logic [31:0] duty;
        logic [31:0] ph;
        case ($urandom_range(0, 5))
            0: begin
                ws = 32'h8000_0000;
                we = 32'h7fff_ffff;
            end
            1, 2: begin
                ws = $urandom;
                we = $urandom;
                if ($signed(ws) > $signed(we)) begin
                    swap = ws;
                    ws   = we;
                    we   = swap;
                end
            end
            3: begin
                ws = $urandom;
                we = ws + $urandom_range(0, 200000);
                if ($signed(we) < $signed(ws)) begin
                    we = 32'h7fff_ffff;
                end
            end
            4: begin
                // may come out empty
                ws = $urandom;
                we = $urandom;
            end
            default: begin
                ws = 32'd0 - $urandom_range(0, 300000);
                we = $urandom_range(0, 300000);
            end
        endcase
        case ($urandom_range(0, 5))
            0:       per = 32'd0;
            1:       per = $urandom_range(1, 16);
            2:       per = $urandom_range(17, 200000);
            3:       per = 32'h7fff_ffff;
            default: per = $urandom & 32'h7fff_ffff;
        endcase
        case ($urandom_range(0, 5))
            0:       duty = 32'd0;
            1:       duty = 32'd65536;
            2:       duty = $urandom_range(65537, 262143);
            default: duty = $urandom_range(1, 65535);
        endcase
        case ($urandom_range(0, 2))
            0:       ph = 32'd0;
            1:       ph = $urandom_range(0, 400000);
            default: ph = $urandom;
        endcase
        set_all(ws, we, per, duty, ph, pick_level(), pick_level());
    endtask

    // Hold off until the pipeline is empty and every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_times.size() != 0 || i_sample_valid
               || expected_levels.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Sample driver: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_sample_valid <= 1'b0;
        end else begin
            if (i_sample_valid && o_sample_ready) begin
                expected_levels.push_back(predict_level(pending_times.pop_front()));
            end
            if (!i_sample_valid || o_sample_ready) begin
                if (gap_left != 0) begin
                    gap_left       <= gap_left - 1;
                    i_sample_valid <= 1'b0;
                end else if (pending_times.size() != 0) begin
                    i_sample_valid <= 1'b1;
                    i_sample_time  <= pending_times[0];
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 32);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_sample_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: switches between always ready, coin-flip and long stalls
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (!i_rst_n) begin
            i_result_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left     <= stall_left - 1;
            i_result_ready <= 1'b0;
        end else if (ready_mode == 1) begin
            i_result_ready <= $urandom_range(0, 1);
        end else if (ready_mode == 2 && $urandom_range(0, 7) == 0) begin
            stall_left     <= $urandom_range(1, 40);
            i_result_ready <= 1'b0;
        end else begin
            i_result_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid && i_result_ready) begin
            got_level = {o_factor_value, o_inside_window, o_pulse_high, o_saturated};
            if (expected_levels.size() == 0) begin
                $display("%0t: result with no sample outstanding: level %h in %b hi %b sat %b",
                         $time, o_factor_value, o_inside_window, o_pulse_high, o_saturated);
                fail_count++;
            end else begin
                want_level = expected_levels.pop_front();
                if (got_level !== want_level) begin
                    $display("%0t: expected level %h in %b hi %b sat %b, got %h in %b hi %b sat %b",
                             $time, want_level.level, want_level.in_win, want_level.high,
                             want_level.sat, got_level.level, got_level.in_win,
                             got_level.high, got_level.sat);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: no transfer on any port for too long
    always @(posedge i_clk) begin
        if ((i_sample_valid && o_sample_ready) || (o_result_valid && i_result_ready)
            || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: one-point window at zero
        @(negedge i_clk);
        pending_times.push_back(32'h0000_0000);
        pending_times.push_back(32'hffff_ffff);
        pending_times.push_back(32'h0000_0001);
        pending_times.push_back(32'h7fff_ffff);
        pending_times.push_back(32'h8000_0000);
        wait_drained();

        // Full window, zero period, positive clipping, high and low halves
        set_all(32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd32768, 32'd0,
                32'h7fff_ffff, 32'd1);
        @(negedge i_clk);
        pending_times.push_back(32'h8000_0000);
        pending_times.push_back(32'h7fff_ffff);
        pending_times.push_back(32'h0000_0000);
        pending_times.push_back(32'h0000_7fff);
        pending_times.push_back(32'h0000_8000);
        pending_times.push_back(32'h0000_ffff);
        pending_times.push_back(32'h0001_0000);
        wait_drained();

        // Empty window: start above end
        write_reg(wpg_pkg::REG_WINDOW_START, 32'd5);
        write_reg(wpg_pkg::REG_WINDOW_END, 32'hffff_fffb);
        @(negedge i_clk);
        pending_times.push_back(32'd5);
        pending_times.push_back(32'hffff_fffb);
        pending_times.push_back(32'd0);
        wait_drained();

        // Full duty, largest period, most negative phase, negative clipping
        set_all(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd65536,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        @(negedge i_clk);
        pending_times.push_back(32'h8000_0000);
        pending_times.push_back(32'h7fff_ffff);
        pending_times.push_back(32'h0000_0000);
        pending_times.push_back(32'h5555_aaaa);
        wait_drained();

        // Zero duty: never high
        set_all(32'h8000_0000, 32'h7fff_ffff, 32'd3, 32'd0, 32'd0,
                32'h0001_0000, 32'h1234_5678);
        @(negedge i_clk);
        pending_times.push_back(32'd0);
        pending_times.push_back(32'd1);
        pending_times.push_back(32'd2);
        wait_drained();

        // Largest duty code, smallest period, narrow window, largest phase
        set_all(32'hffff_fff6, 32'd10, 32'd1, 32'h0003_ffff, 32'h7fff_ffff,
                32'hffff_0000, 32'h0000_8000);
        @(negedge i_clk);
        pending_times.push_back(32'hffff_fff6);
        pending_times.push_back(32'd10);
        pending_times.push_back(32'd11);
        wait_drained();

        while (random_samples < RANDOM_ITEMS) begin
            random_config();
            phase_len = $urandom_range(60, 160);
            @(negedge i_clk);
            repeat (phase_len) begin
                pending_times.push_back(pick_time());
            end
            random_samples += phase_len;
            wait_drained();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && expected_levels.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/wpg_pkg.sv
rtl/core/wpg_rem_pipe.sv
rtl/core/windowed_pulse_train_generator.sv
tb/sv/windowed_pulse_train_generator_test.sv
